/* src/sxl_pkg.sv */
// ---------------------------------------------------------------------------
// sxl_pkg: shared types and constants for the sRGB to XYZ / CIELAB converter
// Word types, the Lab f() pipeline depth and the sRGB gamma table function.
// ---------------------------------------------------------------------------
package sxl_pkg;

	localparam int FRAC_BITS_DEF = 8;

	localparam int LIN_W     = 17;   // gamma table entry, Q16 linear light
	localparam int T_W       = 21;   // normalized XYZ, Q20
	localparam int F_W       = 21;   // f(t), Q20
	localparam int DIV_LAT   = 2;    // constant divider latency
	localparam int LABF_LAT  = F_W + 1;
	// knee product exceeds 32 bits, so it is formed in 64
	localparam int T_LIN_MAX = int'((64'd8856 * 64'd1048576) / 64'd1000000);

	typedef struct packed {
		logic [7:0] red;
		logic [7:0] green;
		logic [7:0] blue;
	} pixel_t;

	typedef struct packed {
		logic [14:0]        xyz_x;
		logic [14:0]        xyz_y;
		logic [14:0]        xyz_z;
		logic [14:0]        lab_l;
		logic signed [15:0] lab_a;
		logic signed [15:0] lab_b;
	} result_t;

	// sRGB decode for one code, evaluated at elaboration only
	function automatic longint unsigned gamma_entry(input int c);
		longint unsigned cc, num, u, w, lo, hi, mid, p;
		cc = longint'(c);
		if (cc <= 10) begin
			return (cc * 6553600 + 164730) / 329460;
		end
		num = (1000 * cc + 14025) << 30;
		u   = (num + 134512) / 269025;
		w   = (u * u) >> 30;
		lo  = 0;
		hi  = longint'(1) << 30;
		for (int it = 0; it < 32; it++) begin
			if (lo < hi) begin
				mid = (lo + hi + 1) >> 1;
				p = mid;
				for (int k = 0; k < 4; k++) begin
					p = (p * mid) >> 30;
				end
				if (p <= w) begin
					lo = mid;
				end else begin
					hi = mid - 1;
				end
			end
		end
		return (((w * lo) >> 30) + 8192) >> 14;
	endfunction

endpackage

/* src/sxl_cdiv.sv */
// ---------------------------------------------------------------------------
// sxl_cdiv: pipelined divide by a constant
// Exact floor(num / D) by reciprocal multiply, split in two partial products.
// ---------------------------------------------------------------------------
module sxl_cdiv #(
	parameter int NB = 30,
	parameter int D  = 100,
	parameter int QB = 23
) (
	input  logic          clk,
	input  logic [NB-1:0] num,
	output logic [QB-1:0] quo
);
	import sxl_pkg::*;

	localparam int L  = $clog2(D);
	localparam int S  = NB + L;
	localparam int MW = NB + 1;
	localparam int HW = MW / 2;
	localparam int PW = NB + MW;
	localparam logic [127:0] M_FULL = ((128'd1 << S) + 128'(D) - 128'd1) / 128'(D);
	localparam logic [MW-1:0] M  = M_FULL[MW-1:0];
	localparam logic [HW-1:0] ML = M[HW-1:0];
	localparam logic [MW-HW-1:0] MH = M[MW-1:HW];

	logic [NB+HW-1:0]    pl_s1;
	logic [NB+MW-HW-1:0] ph_s1;
	logic [PW-1:0]       sum;
	logic [QB-1:0]       quo_s2;

	always_ff @(posedge clk) begin
		pl_s1 <= {{HW{1'b0}}, num} * {{NB{1'b0}}, ML};
		ph_s1 <= {{(MW-HW){1'b0}}, num} * {{NB{1'b0}}, MH};
		quo_s2 <= sum[S +: QB];
	end

	assign sum = PW'(pl_s1) + (PW'(ph_s1) << HW);
	assign quo = quo_s2;

endmodule

/* src/sxl_labf.sv */
// ---------------------------------------------------------------------------
// sxl_labf: CIELAB f(t) in Q20
// Bit-per-stage cube root beside the linear segment, selected at the end.
// ---------------------------------------------------------------------------
module sxl_labf (
	input  logic                  clk,
	input  logic [sxl_pkg::T_W-1:0] t,
	output logic [sxl_pkg::F_W-1:0] f
);
	import sxl_pkg::*;

	localparam int CB_W  = F_W;
	localparam int RW    = T_W + 40;
	localparam int Y2W   = 2 * CB_W;
	localparam int DW    = 3 * CB_W + 3;
	localparam int LT_W  = 14;
	localparam int LN_W  = 39;
	localparam int LQ_W  = 20;
	localparam longint LIN_OFS = 64'd137930 * 64'd1048576 + 64'd500000;

	logic [RW-1:0]   rem_s [CB_W];
	logic [CB_W-1:0] y_s   [CB_W];
	logic [Y2W-1:0]  y2_s  [CB_W];
	logic [CB_W-1:0] sel_s;
	logic [LN_W-1:0] ln_s1;
	logic [LQ_W-1:0] lq;
	logic [LQ_W-1:0] lq_d [CB_W-3];
	logic [F_W-1:0]  f_s;

	for (genvar i = 0; i < CB_W; i++) begin : g_cb
		localparam int K = CB_W - 1 - i;
		logic [RW-1:0]   rem_in;
		logic [CB_W-1:0] y_in;
		logic [Y2W-1:0]  y2_in;
		logic [DW-1:0]   delta;
		logic            take;
		if (i == 0) begin : g_first
			assign rem_in = {t, 40'd0};
			assign y_in   = '0;
			assign y2_in  = '0;
		end else begin : g_next
			assign rem_in = rem_s[i-1];
			assign y_in   = y_s[i-1];
			assign y2_in  = y2_s[i-1];
		end
		// (y+b)^3 - y^3 with b = 2^K
		assign delta = ((DW'(y2_in) * DW'(3)) << K) + ((DW'(y_in) * DW'(3)) << (2 * K))
			+ (DW'(1) << (3 * K));
		assign take = delta <= DW'(rem_in);
		always_ff @(posedge clk) begin
			rem_s[i] <= take ? rem_in - RW'(delta) : rem_in;
			y_s[i]   <= take ? (y_in | (CB_W'(1) << K)) : y_in;
			y2_s[i]  <= take ? y2_in + Y2W'((DW'(y_in) << (K + 1)) + (DW'(1) << (2 * K)))
				: y2_in;
		end
	end

	sxl_cdiv #(.NB(LN_W), .D(1000000), .QB(LQ_W)) u_lin_div (
		.clk (clk),
		.num (ln_s1),
		.quo (lq)
	);

	always_ff @(posedge clk) begin
		sel_s <= {sel_s[CB_W-2:0], (t > T_W'(T_LIN_MAX))};
		ln_s1 <= LN_W'(7787000) * LN_W'(t[LT_W-1:0]) + LN_W'(LIN_OFS);
		lq_d[0] <= lq;
		for (int j = 1; j < CB_W - 3; j++) begin
			lq_d[j] <= lq_d[j-1];
		end
		f_s <= sel_s[CB_W-1] ? y_s[CB_W-1] : F_W'(lq_d[CB_W-4]);
	end

	assign f = f_s;

endmodule

/* src/srgb_to_xyz_and_cielab.sv */
// ---------------------------------------------------------------------------
// srgb_to_xyz_and_cielab: sRGB pixel to CIE XYZ and CIELAB (D65)
// Gamma table, D65 matrix, white point scaling, f(t) and Lab assembly.
// ---------------------------------------------------------------------------
// Usage:
//   Drive pixel and raise start for one cycle per word. busy is always low,
//   so a word is taken on every cycle that start is high: one pixel per clock.
//   Each word comes back as one result word marked by done; words leave in
//   the order they came in. A word passes through the pipeline: gamma table,
//   matrix multiply and sum, divide by 100, white point divide, the 21-stage
//   cube root (one root bit per stage), then Lab assembly and rounding.
//   done lasts one cycle; the receiver cannot stall, so there is no
//   backpressure and nothing is buffered beyond the pipeline itself.
//   All fields are fixed point with FRAC_BITS fraction bits, rounded to
//   nearest (ties away from zero) and saturated.
//   Reset clears the valid bits only; words in flight at reset are dropped.
// ---------------------------------------------------------------------------
module srgb_to_xyz_and_cielab #(
	parameter int FRAC_BITS = sxl_pkg::FRAC_BITS_DEF
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             start,
	output logic             busy,
	input  sxl_pkg::pixel_t  pixel,
	output logic             done,
	output sxl_pkg::result_t result
);
	import sxl_pkg::*;

	localparam int XYZ_W   = 23;
	localparam int SUM_W   = 30;
	localparam int T_STG   = 6;
	localparam int LAB_STG = T_STG + DIV_LAT + LABF_LAT + 1;
	localparam int OUT_STG = LAB_STG + 1;
	localparam int XYZ_DLY = LAB_STG - T_STG;
	localparam int XSH     = 16 - FRAC_BITS;
	localparam int XHALF   = (XSH > 0) ? (1 << (XSH - 1)) : 0;
	localparam int LSH     = 20 - FRAC_BITS;
	localparam int LHALF   = 1 << (LSH - 1);
	localparam logic [13:0] COEF [3][3] = '{
		'{14'd4124, 14'd3576, 14'd1805},
		'{14'd2126, 14'd7152, 14'd722},
		'{14'd193,  14'd1192, 14'd9505}
	};

	logic [LIN_W-1:0] gamma_tab [256];
	logic [OUT_STG-1:0] vld_s;
	logic [LIN_W-1:0] lin_s1 [3];
	logic [SUM_W-1:0] prod_s2 [3][3];
	logic [SUM_W-1:0] sum_s3 [3];
	logic [XYZ_W-1:0] xyz [3];
	logic [44:0]      xyz_s6;
	logic [44:0]      xyz_d [XYZ_DLY];
	logic [36:0]      nx_s6;
	logic [27:0]      ny_s6;
	logic [33:0]      nz_s6;
	logic [T_W-1:0]   tx, ty, tz;
	logic [F_W-1:0]   fx, fy, fz;
	logic signed [31:0] l20_s31, a20_s31, b20_s31;
	result_t          result_s32;

	for (genvar gi = 0; gi < 256; gi++) begin : g_gamma
		assign gamma_tab[gi] = LIN_W'(gamma_entry(gi));
	end

	function automatic logic [14:0] xyz_round(input logic [XYZ_W-1:0] v);
		logic [XYZ_W+1:0] r;
		r = (($bits(r))'(v) + ($bits(r))'(XHALF)) >> XSH;
		return (r > ($bits(r))'(32767)) ? 15'h7FFF : r[14:0];
	endfunction

	function automatic logic [15:0] rnd_sat(input logic signed [31:0] v,
		input logic signed [33:0] lo, input logic signed [33:0] hi);
		logic [32:0] mag;
		logic signed [33:0] r;
		mag = v[31] ? 33'(-{v[31], v}) : {v[31], v};
		mag = (mag + 33'(LHALF)) >> LSH;
		r = v[31] ? -$signed({1'b0, mag}) : $signed({1'b0, mag});
		if (r < lo) begin
			r = lo;
		end else if (r > hi) begin
			r = hi;
		end
		return r[15:0];
	endfunction

	assign busy = 1'b0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s <= '0;
		end else begin
			vld_s <= {vld_s[OUT_STG-2:0], start & ~busy};
		end
	end

	always_ff @(posedge clk) begin
		lin_s1[0] <= gamma_tab[pixel.red];
		lin_s1[1] <= gamma_tab[pixel.green];
		lin_s1[2] <= gamma_tab[pixel.blue];
		for (int i = 0; i < 3; i++) begin
			for (int j = 0; j < 3; j++) begin
				prod_s2[i][j] <= SUM_W'(COEF[i][j]) * SUM_W'(lin_s1[j]);
			end
			sum_s3[i] <= prod_s2[i][0] + prod_s2[i][1] + prod_s2[i][2] + SUM_W'(50);
		end
	end

	for (genvar gk = 0; gk < 3; gk++) begin : g_xyz
		sxl_cdiv #(.NB(SUM_W), .D(100), .QB(XYZ_W)) u_div100 (
			.clk (clk),
			.num (sum_s3[gk]),
			.quo (xyz[gk])
		);
	end

	always_ff @(posedge clk) begin
		xyz_s6 <= {xyz_round(xyz[0]), xyz_round(xyz[1]), xyz_round(xyz[2])};
		nx_s6  <= 37'(xyz[0]) * 37'd16000 + 37'd47523;
		ny_s6  <= 28'(xyz[1]) * 28'd16 + 28'd50;
		nz_s6  <= 34'(xyz[2]) * 34'd1600 + 34'd5444;
		xyz_d[0] <= xyz_s6;
		for (int j = 1; j < XYZ_DLY; j++) begin
			xyz_d[j] <= xyz_d[j-1];
		end
	end

	sxl_cdiv #(.NB(37), .D(95047), .QB(T_W)) u_tx (.clk(clk), .num(nx_s6), .quo(tx));
	sxl_cdiv #(.NB(28), .D(100),   .QB(T_W)) u_ty (.clk(clk), .num(ny_s6), .quo(ty));
	sxl_cdiv #(.NB(34), .D(10888), .QB(T_W)) u_tz (.clk(clk), .num(nz_s6), .quo(tz));

	sxl_labf u_fx (.clk(clk), .t(tx), .f(fx));
	sxl_labf u_fy (.clk(clk), .t(ty), .f(fy));
	sxl_labf u_fz (.clk(clk), .t(tz), .f(fz));

	always_ff @(posedge clk) begin
		l20_s31 <= 32'sd116 * $signed(32'(fy)) - 32'sd16777216;
		a20_s31 <= 32'sd500 * ($signed(32'(fx)) - $signed(32'(fy)));
		b20_s31 <= 32'sd200 * ($signed(32'(fy)) - $signed(32'(fz)));
		result_s32.xyz_x <= xyz_d[XYZ_DLY-1][44:30];
		result_s32.xyz_y <= xyz_d[XYZ_DLY-1][29:15];
		result_s32.xyz_z <= xyz_d[XYZ_DLY-1][14:0];
		result_s32.lab_l <= 15'(rnd_sat(l20_s31, 34'sd0, 34'sd32767));
		result_s32.lab_a <= rnd_sat(a20_s31, -34'sd32768, 34'sd32767);
		result_s32.lab_b <= rnd_sat(b20_s31, -34'sd32768, 34'sd32767);
	end

	assign done   = vld_s[OUT_STG-1];
	assign result = result_s32;

	// every word taken comes out marked by done
	a_latency: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy) |-> ##(OUT_STG) done)
		else $error("word lost in pipeline");

	// no result without a word taken earlier
	a_no_spurious: assert property (@(posedge clk) disable iff (!arst_n)
		!$past(start && !busy, OUT_STG) |-> !done)
		else $error("result without input word");

	// black decodes to zero X and Y and zero lightness
	a_black: assert property (@(posedge clk) disable iff (!arst_n)
		(start && pixel.red == 8'd0 && pixel.green == 8'd0 && pixel.blue == 8'd0)
		|-> ##(OUT_STG) (result.xyz_x == 15'd0 && result.xyz_y == 15'd0
		&& result.lab_l == 15'd0))
		else $error("black pixel mismatch");

endmodule

/* tb/srgb_to_xyz_and_cielab_tb.sv */
`timescale 1ns / 100ps
// ---------------------------------------------------------------------------
// srgb_to_xyz_and_cielab_tb: self-checking bench for the sRGB to XYZ / Lab block
// A directed table of pixels followed by random bursts. Every result word is
// compared field by field with a bit-exact integer conversion of the pixel.
// ---------------------------------------------------------------------------
module srgb_to_xyz_and_cielab_tb;
	import sxl_pkg::*;

	localparam int FB          = 8;
	localparam int N_RANDOM    = 1300;
	localparam int LATENCY     = 32;
	localparam longint MAX_CYC = 200000;

	logic    clk;
	logic    arst_n;
	logic    start;
	logic    busy;
	pixel_t  pixel;
	logic    done;
	result_t result;

	result_t lab_queue[$];
	longint  cycles;
	int      errors;
	longint unsigned decode_rom[256];

	typedef struct {
		pixel_t  px;
		logic    known;
		result_t res;
	} row_t;
	row_t directed[$];

	srgb_to_xyz_and_cielab #(.FRAC_BITS(FB)) dut (
		.clk(clk), .arst_n(arst_n), .start(start), .busy(busy),
		.pixel(pixel), .done(done), .result(result)
	);

	always begin
		clk = 1'b0; #5;
		clk = 1'b1; #5;
	end

	// sRGB decode table in Q16
	function automatic longint unsigned srgb_decode(input int code);
		longint unsigned c, u, w, lo, hi, mid, p;
		c = code;
		if (c <= 10) return (c * 6553600 + 164730) / 329460;
		u  = (((1000 * c + 14025) << 30) + 134512) / 269025;
		w  = (u * u) >> 30;
		lo = 0;
		hi = 64'd1 << 30;
		while (lo < hi) begin
			mid = (lo + hi + 1) >> 1;
			p = mid;
			repeat (4) p = (p * mid) >> 30;
			if (p <= w) lo = mid;
			else hi = mid - 1;
		end
		return (((w * lo) >> 30) + 8192) >> 14;
	endfunction

	function automatic longint lab_curve(input longint unsigned t);
		longint unsigned tgt, lo, hi, mid;
		if (t * 1000000 > 64'd8856 * 1048576) begin
			tgt = t << 40;
			lo = 0;
			hi = (64'd1 << 21) - 1;
			while (lo < hi) begin
				mid = (lo + hi + 1) >> 1;
				if (mid * mid * mid <= tgt) lo = mid;
				else hi = mid - 1;
			end
			return lo;
		end
		return (7787000 * t + 64'd137930 * 1048576 + 500000) / 1000000;
	endfunction

	function automatic longint round_away(input longint v, input int s);
		longint m;
		m = v < 0 ? -v : v;
		m = (m + (64'sd1 <<< (s - 1))) >>> s;
		return v < 0 ? -m : m;
	endfunction

	function automatic longint sat(input longint v, input longint lo, input longint hi);
		return v < lo ? lo : (v > hi ? hi : v);
	endfunction

	function automatic result_t convert_pixel(input pixel_t px);
		longint unsigned lin[3], xyz[3], tx, ty, tz;
		longint fx, fy, fz;
		result_t r;
		lin[0] = decode_rom[px.red];
		lin[1] = decode_rom[px.green];
		lin[2] = decode_rom[px.blue];
		xyz[0] = (4124 * lin[0] + 3576 * lin[1] + 1805 * lin[2] + 50) / 100;
		xyz[1] = (2126 * lin[0] + 7152 * lin[1] + 722 * lin[2] + 50) / 100;
		xyz[2] = (193 * lin[0] + 1192 * lin[1] + 9505 * lin[2] + 50) / 100;
		r.xyz_x = 15'(sat(round_away(xyz[0], 16 - FB), 0, 32767));
		r.xyz_y = 15'(sat(round_away(xyz[1], 16 - FB), 0, 32767));
		r.xyz_z = 15'(sat(round_away(xyz[2], 16 - FB), 0, 32767));
		tx = (xyz[0] * 16000 + 47523) / 95047;
		ty = (xyz[1] * 16 + 50) / 100;
		tz = (xyz[2] * 1600 + 5444) / 10888;
		fx = lab_curve(tx);
		fy = lab_curve(ty);
		fz = lab_curve(tz);
		r.lab_l = 15'(sat(round_away(116 * fy - 16 * 1048576, 20 - FB), 0, 32767));
		r.lab_a = 16'(sat(round_away(500 * (fx - fy), 20 - FB), -32768, 32767));
		r.lab_b = 16'(sat(round_away(200 * (fy - fz), 20 - FB), -32768, 32767));
		return r;
	endfunction

	function automatic row_t mk_row(input int r, input int g, input int b);
		row_t x;
		x.px = '{red: 8'(r), green: 8'(g), blue: 8'(b)};
		x.known = 1'b0;
		x.res = '0;
		return x;
	endfunction

	task automatic send_pixel(input pixel_t px);
		start <= 1'b1;
		pixel <= px;
		@(posedge clk);
		while (busy) @(posedge clk);
		lab_queue.push_back(convert_pixel(px));
	endtask

	task automatic idle_gap(input int n);
		start <= 1'b0;
		pixel <= pixel_t'($urandom);
		repeat (n) @(posedge clk);
	endtask

	// result checker
	always @(posedge clk) begin
		result_t exp_res;
		if (arst_n && done) begin
			if (lab_queue.size() == 0) begin
				$error("result word with nothing expected");
				errors++;
			end else begin
				exp_res = lab_queue.pop_front();
				if (result.xyz_x !== exp_res.xyz_x) begin
					$error("xyz_x exp %0d got %0d", exp_res.xyz_x, result.xyz_x); errors++;
				end
				if (result.xyz_y !== exp_res.xyz_y) begin
					$error("xyz_y exp %0d got %0d", exp_res.xyz_y, result.xyz_y); errors++;
				end
				if (result.xyz_z !== exp_res.xyz_z) begin
					$error("xyz_z exp %0d got %0d", exp_res.xyz_z, result.xyz_z); errors++;
				end
				if (result.lab_l !== exp_res.lab_l) begin
					$error("lab_l exp %0d got %0d", exp_res.lab_l, result.lab_l); errors++;
				end
				if (result.lab_a !== exp_res.lab_a) begin
					$error("lab_a exp %0d got %0d", exp_res.lab_a, result.lab_a); errors++;
				end
				if (result.lab_b !== exp_res.lab_b) begin
					$error("lab_b exp %0d got %0d", exp_res.lab_b, result.lab_b); errors++;
				end
			end
		end
	end

	always @(posedge clk) begin
		cycles++;
		if (cycles > MAX_CYC) begin
			$display("FAILURE");
			$finish;
		end
	end

	initial begin
		row_t rw;
		pixel_t px;
		int burst;
		int sent;
		cycles = 0;
		errors = 0;
		start = 1'b0;
		pixel = '0;
		arst_n = 1'b0;
		for (int c = 0; c < 256; c++) decode_rom[c] = srgb_decode(c);

		// black (L clamps at zero) with its result given directly, and white
		rw = mk_row(0, 0, 0); rw.known = 1'b1; rw.res = '0; directed.push_back(rw);
		rw = mk_row(255, 255, 255); directed.push_back(rw);
		directed.push_back(mk_row(255, 0, 0));
		directed.push_back(mk_row(0, 255, 0));
		directed.push_back(mk_row(0, 0, 255));
		directed.push_back(mk_row(255, 255, 0));
		directed.push_back(mk_row(0, 255, 255));
		directed.push_back(mk_row(255, 0, 255));
		// gamma linear segment edge
		directed.push_back(mk_row(10, 10, 10));
		directed.push_back(mk_row(11, 11, 11));
		directed.push_back(mk_row(1, 1, 1));
		directed.push_back(mk_row(10, 0, 11));
		// near the Lab f() knee
		directed.push_back(mk_row(20, 20, 20));
		directed.push_back(mk_row(24, 24, 24));
		directed.push_back(mk_row(25, 25, 25));
		directed.push_back(mk_row(128, 128, 128));
		directed.push_back(mk_row(170, 85, 170));
		directed.push_back(mk_row(85, 170, 85));
		directed.push_back(mk_row(0, 0, 1));
		directed.push_back(mk_row(254, 1, 127));

		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (directed[i]) begin
			if (directed[i].known && convert_pixel(directed[i].px) !== directed[i].res) begin
				$error("table row %0d disagrees with conversion", i);
				errors++;
			end
			send_pixel(directed[i].px);
		end

		sent = 0;
		while (sent < N_RANDOM) begin
			burst = $urandom_range(1, 40);
			for (int k = 0; k < burst && sent < N_RANDOM; k++) begin
				if ($urandom_range(0, 9) == 0)
					px = '{red: 8'($urandom_range(0, 12)), green: 8'($urandom_range(0, 12)),
						blue: 8'($urandom_range(0, 12))};
				else
					px = pixel_t'($urandom);
				send_pixel(px);
				sent++;
			end
			if ($urandom_range(0, 3) != 0) idle_gap($urandom_range(1, 12));
		end
		idle_gap(1);

		while (lab_queue.size() != 0) @(posedge clk);
		repeat (LATENCY + 8) @(posedge clk);
		if (errors == 0) $display("SUCCESS");
		else $display("FAILURE");
		$finish;
	end

endmodule
